/* design/area_weighted_light_select_macros.svh */
// ----------------------------------------------------------------------------
// Area-weighted light select: assertion macros
// Concurrent check wrappers clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AREA_WEIGHTED_LIGHT_SELECT_MACROS_SVH
`define AREA_WEIGHTED_LIGHT_SELECT_MACROS_SVH

`ifndef ASSERT_OFF
`define AWLS_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AWLS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AWLS_ASSERT(lbl, ante, cons, msg)
`define AWLS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* design/awls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Area-weighted light select: shared package
// Field widths, result kinds and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package awls_pkg;

    localparam int MAX_LIGHTS_DEF = 256;

    localparam int FUNC_W   = 1;
    localparam int IDX_W    = 8;
    localparam int AREA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int TOTAL_W  = 40;
    localparam int LOCAL_W  = 17;
    localparam int COUNT_W  = 9;
    localparam int TARGET_W = FRAC_W + TOTAL_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [LOCAL_W-1:0] ONE_Q16   = LOCAL_W'(1) << FRAC_W;

    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_SELECT = 1'b1;

    typedef logic [1:0] t_out_kind;
    localparam t_out_kind OUT_NONE = 2'd0;
    localparam t_out_kind OUT_HIT  = 2'd1;
    localparam t_out_kind OUT_LAST = 2'd2;

    typedef struct packed {
        logic      cfg_we;
        logic      capture;
        logic      clr;
        logic      mem_we;
        logic      walk_init;
        logic      walk_run;
        logic      walk_query;
        logic      tgt_load;
        logic      sum_store;
        logic      div_init;
        logic      div_step;
        logic      out_load;
        t_out_kind out_kind;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic walk_done;
        logic hit;
        logic total_zero;
        logic div_done;
    } t_status;

endpackage

/* design/awls_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Area-weighted light select: datapath
// Area memory, running total, cumulative walk with compare, 16-step restoring
// divider for the local fraction, and the result register.
// ----------------------------------------------------------------------------
module awls_dp #(
    parameter int MAX_LIGHTS = awls_pkg::MAX_LIGHTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  awls_pkg::t_cmd               i_cmd,
    output awls_pkg::t_status            o_status,
    input  logic [awls_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [awls_pkg::AREA_W-1:0]  i_area_value,
    input  logic [awls_pkg::FRAC_W-1:0]  i_pick_frac,
    input  logic [awls_pkg::COUNT_W-1:0] i_light_count,
    output logic                         o_found,
    output logic [awls_pkg::IDX_W-1:0]   o_light_index,
    output logic [awls_pkg::AREA_W-1:0]  o_light_area,
    output logic [awls_pkg::TOTAL_W-1:0] o_total_area,
    output logic [awls_pkg::LOCAL_W-1:0] o_local_sample
);

    localparam int AW   = $clog2(MAX_LIGHTS);
    localparam int NW   = ($clog2(MAX_LIGHTS + 1) > awls_pkg::COUNT_W) ?
                          $clog2(MAX_LIGHTS + 1) : awls_pkg::COUNT_W;
    localparam int CUMW = awls_pkg::AREA_W + AW;
    localparam int CMPW = (CUMW + awls_pkg::FRAC_W > awls_pkg::TARGET_W) ?
                          CUMW + awls_pkg::FRAC_W : awls_pkg::TARGET_W;
    localparam int SUMW = (CUMW > awls_pkg::TOTAL_W) ? CUMW : awls_pkg::TOTAL_W + 1;
    localparam int REMW = awls_pkg::AREA_W + awls_pkg::FRAC_W;
    localparam int DCW  = $clog2(awls_pkg::FRAC_W + 1);

    logic [awls_pkg::AREA_W-1:0]   r_mem [MAX_LIGHTS];
    logic [awls_pkg::AREA_W-1:0]   r_rdata;

    logic [awls_pkg::COUNT_W-1:0]  r_count;
    logic [awls_pkg::TOTAL_W-1:0]  r_total;
    logic [awls_pkg::IDX_W-1:0]    r_in_idx;
    logic [awls_pkg::AREA_W-1:0]   r_in_area;
    logic [awls_pkg::FRAC_W-1:0]   r_in_u;
    logic [awls_pkg::TARGET_W-1:0] r_target;

    logic [NW-1:0]                 r_addr;
    logic                          r_rvld;
    logic [NW-1:0]                 r_ridx;
    logic [CUMW-1:0]               r_cum;
    logic [CUMW-1:0]               r_prev;
    logic                          r_hit;
    logic                          r_have_last;
    logic [NW-1:0]                 r_last_idx;
    logic [awls_pkg::AREA_W-1:0]   r_last_area;
    logic [NW-1:0]                 r_sel_idx;
    logic [awls_pkg::AREA_W-1:0]   r_sel_area;

    logic [REMW-1:0]               r_rem;
    logic [REMW-1:0]               r_dsor;
    logic [awls_pkg::FRAC_W-1:0]   r_quo;
    logic [DCW-1:0]                r_dcnt;

    logic                          r_found;
    logic [awls_pkg::IDX_W-1:0]    r_light_index;
    logic [awls_pkg::AREA_W-1:0]   r_light_area;
    logic [awls_pkg::TOTAL_W-1:0]  r_total_area;
    logic [awls_pkg::LOCAL_W-1:0]  r_local_sample;

    logic [NW-1:0]                 count_ext;
    logic [NW-1:0]                 n_used;
    logic [NW-1:0]                 idx_ext;
    logic                          in_range;
    logic                          mem_wr;
    logic [AW-1:0]                 mem_waddr;
    logic [awls_pkg::AREA_W-1:0]   mem_wdata;
    logic                          walk_more;
    logic [CUMW-1:0]               cum_next;
    logic [CMPW-1:0]               target_x;
    logic [CMPW-1:0]               cum_sh;
    logic                          hit_now;
    logic                          issue;
    logic                          proc;
    logic [SUMW-1:0]               cum_wide;
    logic [awls_pkg::TOTAL_W-1:0]  total_sat;
    logic [awls_pkg::TARGET_W-1:0] prod;
    logic [CMPW-1:0]               rem_full;
    logic                          div_ge;

    assign count_ext = NW'(r_count);
    assign n_used    = (count_ext > NW'(MAX_LIGHTS)) ? NW'(MAX_LIGHTS) : count_ext;
    assign idx_ext   = NW'(r_in_idx);
    assign in_range  = idx_ext < NW'(MAX_LIGHTS);

    assign mem_wr    = i_cmd.clr || (i_cmd.mem_we && in_range);
    assign mem_waddr = i_cmd.clr ? r_addr[AW-1:0] : idx_ext[AW-1:0];
    assign mem_wdata = i_cmd.clr ? '0 : r_in_area;

    assign walk_more = r_addr < n_used;
    assign cum_next  = r_cum + CUMW'(r_rdata);
    assign target_x  = CMPW'(r_target);
    assign cum_sh    = CMPW'({cum_next, {awls_pkg::FRAC_W{1'b0}}});
    assign proc      = i_cmd.walk_run && r_rvld && !r_hit;
    assign hit_now   = proc && i_cmd.walk_query && (r_rdata != '0) && (target_x < cum_sh);
    assign issue     = i_cmd.walk_run && walk_more && !r_hit && !hit_now;

    assign cum_wide  = SUMW'(r_cum);
    assign total_sat = (cum_wide > SUMW'(awls_pkg::TOTAL_MAX)) ?
                       awls_pkg::TOTAL_MAX : cum_wide[awls_pkg::TOTAL_W-1:0];

    assign prod      = awls_pkg::TARGET_W'(r_in_u) * awls_pkg::TARGET_W'(r_total);
    assign rem_full  = target_x - CMPW'({r_prev, {awls_pkg::FRAC_W{1'b0}}});
    assign div_ge    = r_rem >= r_dsor;

    assign o_status.clr_done   = r_addr == NW'(MAX_LIGHTS - 1);
    assign o_status.walk_done  = r_hit || (!walk_more && !r_rvld);
    assign o_status.hit        = r_hit;
    assign o_status.total_zero = r_total == '0;
    assign o_status.div_done   = r_dcnt == DCW'(awls_pkg::FRAC_W);

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_total     <= '0;
            r_addr      <= '0;
            r_rvld      <= 1'b0;
            r_hit       <= 1'b0;
            r_have_last <= 1'b0;
        end else begin
            if (i_cmd.cfg_we) begin
                r_count <= i_light_count;
            end
            if (i_cmd.sum_store) begin
                r_total <= total_sat;
            end
            if (i_cmd.walk_init) begin
                r_addr      <= '0;
                r_rvld      <= 1'b0;
                r_hit       <= 1'b0;
                r_have_last <= 1'b0;
            end else begin
                if (i_cmd.clr || issue) begin
                    r_addr <= r_addr + NW'(1);
                end
                r_rvld <= issue;
                if (hit_now) begin
                    r_hit <= 1'b1;
                end
                if (proc && i_cmd.walk_query && (r_rdata != '0)) begin
                    r_have_last <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_idx  <= i_entry_index;
            r_in_area <= i_area_value;
            r_in_u    <= i_pick_frac;
        end
        if (i_cmd.tgt_load) begin
            r_target <= prod;
        end
        if (issue) begin
            r_ridx <= r_addr;
        end
        if (i_cmd.walk_init) begin
            r_cum <= '0;
        end else if (proc) begin
            r_cum <= cum_next;
        end
        if (proc && i_cmd.walk_query && (r_rdata != '0)) begin
            r_last_idx  <= r_ridx;
            r_last_area <= r_rdata;
        end
        if (hit_now) begin
            r_sel_idx  <= r_ridx;
            r_sel_area <= r_rdata;
            r_prev     <= r_cum;
        end
        if (i_cmd.div_init) begin
            r_rem  <= rem_full[REMW-1:0];
            r_dsor <= {1'b0, r_sel_area, {(awls_pkg::FRAC_W - 1){1'b0}}};
            r_quo  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= div_ge ? (r_rem - r_dsor) : r_rem;
            r_quo  <= {r_quo[awls_pkg::FRAC_W-2:0], div_ge};
            r_dsor <= r_dsor >> 1;
            r_dcnt <= r_dcnt + DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_kind)
                awls_pkg::OUT_HIT: begin
                    r_found        <= 1'b1;
                    r_light_index  <= r_sel_idx[awls_pkg::IDX_W-1:0];
                    r_light_area   <= r_sel_area;
                    r_total_area   <= r_total;
                    r_local_sample <= awls_pkg::LOCAL_W'(r_quo);
                end
                awls_pkg::OUT_LAST: begin
                    r_found        <= r_have_last;
                    r_light_index  <= r_have_last ? r_last_idx[awls_pkg::IDX_W-1:0] : '0;
                    r_light_area   <= r_have_last ? r_last_area : '0;
                    r_total_area   <= r_have_last ? r_total : '0;
                    r_local_sample <= r_have_last ? awls_pkg::ONE_Q16 : '0;
                end
                default: begin
                    r_found        <= 1'b0;
                    r_light_index  <= '0;
                    r_light_area   <= '0;
                    r_total_area   <= '0;
                    r_local_sample <= '0;
                end
            endcase
        end
    end

    assign o_found        = r_found;
    assign o_light_index  = r_light_index;
    assign o_light_area   = r_light_area;
    assign o_total_area   = r_total_area;
    assign o_local_sample = r_local_sample;

endmodule

/* design/awls_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Area-weighted light select: controller
// Sequences memory clear, entry writes, total recompute and selection queries,
// and owns the channel handshakes.
// ----------------------------------------------------------------------------
module awls_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [awls_pkg::FUNC_W-1:0] i_func,
    output logic                        o_valid,
    input  logic                        i_stall,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    output awls_pkg::t_cmd              o_cmd,
    input  awls_pkg::t_status           i_status
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WRMEM = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_QLOAD = 3'd4;
    localparam logic [2:0] S_QWALK = 3'd5;
    localparam logic [2:0] S_QDIV  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    awls_pkg::t_out_kind r_kind;
    awls_pkg::t_out_kind n_kind;
    logic                r_out_vld;
    awls_pkg::t_cmd      cmd;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr    = 1'b1;
                cmd.cfg_we = i_cfg_valid;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.cfg_we = i_cfg_valid;
                if (i_cfg_valid) begin
                    cmd.walk_init = 1'b1;
                    n_state       = S_SUM;
                end else if (i_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = (i_func == awls_pkg::FUNC_WRITE) ? S_WRMEM : S_QLOAD;
                end
            end
            S_WRMEM: begin
                cmd.mem_we    = 1'b1;
                cmd.walk_init = 1'b1;
                n_state       = S_SUM;
            end
            S_SUM: begin
                cmd.walk_run = 1'b1;
                if (i_status.walk_done) begin
                    cmd.sum_store = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_QLOAD: begin
                cmd.tgt_load  = 1'b1;
                cmd.walk_init = 1'b1;
                if (i_status.total_zero) begin
                    n_kind  = awls_pkg::OUT_NONE;
                    n_state = S_FIN;
                end else begin
                    n_state = S_QWALK;
                end
            end
            S_QWALK: begin
                cmd.walk_run   = 1'b1;
                cmd.walk_query = 1'b1;
                if (i_status.walk_done) begin
                    if (i_status.hit) begin
                        cmd.div_init = 1'b1;
                        n_state      = S_QDIV;
                    end else begin
                        n_kind  = awls_pkg::OUT_LAST;
                        n_state = S_FIN;
                    end
                end
            end
            S_QDIV: begin
                if (i_status.div_done) begin
                    n_kind  = awls_pkg::OUT_HIT;
                    n_state = S_FIN;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_vld || !i_stall) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = r_kind;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_kind    <= awls_pkg::OUT_NONE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            if (cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_valid     = r_out_vld;
    assign o_stall     = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE) || (r_state == S_CLEAR);

endmodule

/* design/area_weighted_light_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Area-weighted light select: top level
// Picks a light entry with probability proportional to its area.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): func 0 writes area_value to entry_index,
// func 1 asks for a selection with the Q0.16 fraction pick_frac. One item
// is in work at a time; a write gives no result, a selection gives one.
// Output channel (o_valid / i_stall): found, index, area, total, local sample.
// Config channel (i_cfg_valid / o_cfg_ready): light_count, write while idle.
// With n = min(light_count, MAX_LIGHTS): a write and a config write both
//   re-add the total from memory over n entries, one entry a cycle through
//   the single read port; a selection takes one multiply, the walk over at
//   most n entries, then the bit-serial divider.
// After reset the area memory is swept to zero with o_stall high; config
// writes are taken during the sweep.
// A finished result sits in the output register; while i_stall is high it
// holds, and a following write item is still taken. A second result waits
// inside until the register frees.
// ----------------------------------------------------------------------------
`include "area_weighted_light_select_macros.svh"

module area_weighted_light_select #(
    parameter int MAX_LIGHTS = awls_pkg::MAX_LIGHTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [awls_pkg::FUNC_W-1:0]  i_func,
    input  logic [awls_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [awls_pkg::AREA_W-1:0]  i_area_value,
    input  logic [awls_pkg::FRAC_W-1:0]  i_pick_frac,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_found,
    output logic [awls_pkg::IDX_W-1:0]   o_light_index,
    output logic [awls_pkg::AREA_W-1:0]  o_light_area,
    output logic [awls_pkg::TOTAL_W-1:0] o_total_area,
    output logic [awls_pkg::LOCAL_W-1:0] o_local_sample,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [awls_pkg::COUNT_W-1:0] i_light_count
);

    awls_pkg::t_cmd    cmd;
    awls_pkg::t_status status;

    awls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    awls_dp #(
        .MAX_LIGHTS (MAX_LIGHTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_entry_index   (i_entry_index),
        .i_area_value    (i_area_value),
        .i_pick_frac     (i_pick_frac),
        .i_light_count   (i_light_count),
        .o_found         (o_found),
        .o_light_index   (o_light_index),
        .o_light_area    (o_light_area),
        .o_total_area    (o_total_area),
        .o_local_sample  (o_local_sample)
    );

    `AWLS_ASSERT(a_cfg_blocks_input, i_cfg_valid && o_cfg_ready, o_stall, "input open during config transfer")
    `AWLS_ASSERT_NXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "input open right after transfer")
    `AWLS_ASSERT(a_found_has_total, o_valid && o_found, o_total_area != '0, "found with zero total")
    `AWLS_ASSERT(a_miss_is_zero, o_valid && !o_found, o_light_area == '0 && o_local_sample == '0, "miss result not cleared")
    `AWLS_ASSERT(a_local_bound, o_valid && o_local_sample[16], o_local_sample[15:0] == '0, "local sample above one")

endmodule
